FILE: rtl/dss_pkg.sv
package dss_pkg;

	// Default build constants.
	localparam int MAX_DELIM_BYTES_DEF = 8;
	localparam int POS_WIDTH_DEF       = 16;

	// Fixed widths of the port fields.
	localparam int SEG_W        = 16;
	localparam int DELIM_REG_W  = 64;
	localparam int DLEN_REG_W   = 4;
	localparam int CFG_ADDR_W   = 1;
	localparam int CFG_DATA_W   = 64;

	// Entries in the event queue between front and back; a power of two.
	localparam int QUEUE_DEPTH  = 4;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_DELIM_BYTES  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_DELIM_LENGTH = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// One result word as it leaves the block.
	typedef struct packed {
		logic [SEG_W-1:0] start;
		logic [SEG_W-1:0] length;
		logic             last;
		logic [1:0]       status;
	} result_t;

	// Everything one byte produces: one result, optionally followed by an
	// empty final segment (delimiter completed on the final byte).
	typedef struct packed {
		logic             two;
		result_t          first;
		logic [SEG_W-1:0] second_start;
	} event_t;

endpackage

FILE: rtl/dss_front.sv
module dss_front #(
	parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES_DEF,
	parameter int POS_WIDTH       = dss_pkg::POS_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        in_byte,
	input  logic                              in_last,
	input  logic                              queue_full,
	output logic                              ev_push,
	output dss_pkg::event_t                   ev
);

	localparam int WIN_W = 8 * MAX_DELIM_BYTES;
	localparam int DLW   = $clog2(MAX_DELIM_BYTES + 1);
	localparam int PW    = POS_WIDTH;

	logic [WIN_W-1:0] delim_q;
	logic [DLW-1:0]   dlen_q;
	logic [WIN_W-1:0] win_q;
	logic [PW-1:0]    pos_q;
	logic             ovf_q;
	logic [PW-1:0]    seg_q;

	logic               accept;
	logic               full_str;
	logic [PW:0]        pos1;
	logic [PW:0]        dl_ext;
	logic [PW:0]        mstart;
	logic [WIN_W-1:0]   win_n;
	logic [MAX_DELIM_BYTES:0] match_len;
	logic               hit;
	logic [3:0]         dlen_wr;

	// Zero-extend or truncate a position to the port field width.
	function automatic logic [dss_pkg::SEG_W-1:0] fit(input logic [PW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[dss_pkg::SEG_W-1:0];
	endfunction

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign full_str = ovf_q || (&pos_q);
	assign pos1     = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
	assign dl_ext   = (PW + 1)'(dlen_q);
	assign mstart   = pos1 - dl_ext;
	assign dlen_wr  = cfg_wdata[3:0];

	// Window after the new byte shifts in, newest byte in the low bits.
	always_comb begin
		win_n[7:0] = in_byte;
		for (int i = 1; i < MAX_DELIM_BYTES; i++) begin
			win_n[8*i +: 8] = win_q[8*(i-1) +: 8];
		end
	end

	// Parallel compare of the delimiter against the window for every length.
	always_comb begin
		match_len[0] = 1'b0;
		for (int l = 1; l <= MAX_DELIM_BYTES; l++) begin
			match_len[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (delim_q[8*k +: 8] != win_n[8*(l-1-k) +: 8]) begin
					match_len[l] = 1'b0;
				end
			end
		end
	end

	// A match counts only inside the string and at or after the segment start.
	assign hit = (dlen_q != '0) && (pos1 >= dl_ext) && (mstart >= {1'b0, seg_q})
		&& match_len[dlen_q];

	// Classify the byte into the results it causes.
	always_comb begin
		ev_push               = 1'b0;
		ev.two                = 1'b0;
		ev.first.start        = '0;
		ev.first.length       = '0;
		ev.first.last         = 1'b0;
		ev.first.status       = dss_pkg::STATUS_OK;
		ev.second_start       = fit(pos1[PW-1:0]);
		if (accept) begin
			if (full_str) begin
				if (in_last) begin
					ev_push         = 1'b1;
					ev.first.last   = 1'b1;
					ev.first.status = dss_pkg::STATUS_OVERFLOW;
				end
			end else if (dlen_q == '0) begin
				ev_push         = 1'b1;
				ev.first.start  = fit(pos_q);
				ev.first.length = dss_pkg::SEG_W'(1);
				ev.first.last   = in_last;
			end else if (in_last && (dl_ext > pos1)) begin
				ev_push         = 1'b1;
				ev.first.last   = 1'b1;
				ev.first.status = dss_pkg::STATUS_SHORT;
			end else if (hit) begin
				ev_push         = 1'b1;
				ev.two          = in_last;
				ev.first.start  = fit(seg_q);
				ev.first.length = fit(mstart[PW-1:0] - seg_q);
			end else if (in_last) begin
				ev_push         = 1'b1;
				ev.first.start  = fit(seg_q);
				ev.first.length = fit(pos1[PW-1:0] - seg_q);
				ev.first.last   = 1'b1;
			end
		end
	end

	// Configuration registers; the length saturates at the window size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= '0;
			dlen_q  <= DLW'(1);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				dss_pkg::REG_DELIM_BYTES: begin
					delim_q <= cfg_wdata[WIN_W-1:0];
				end
				dss_pkg::REG_DELIM_LENGTH: begin
					if (dlen_wr > 4'(MAX_DELIM_BYTES)) begin
						dlen_q <= DLW'(MAX_DELIM_BYTES);
					end else begin
						dlen_q <= dlen_wr[DLW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// String state: window, position, overflow mark and segment start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			seg_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				win_q <= '0;
				pos_q <= '0;
				ovf_q <= 1'b0;
				seg_q <= '0;
			end else if (full_str) begin
				ovf_q <= 1'b1;
			end else begin
				win_q <= win_n;
				pos_q <= pos1[PW-1:0];
				if (hit) begin
					seg_q <= pos1[PW-1:0];
				end
			end
		end
	end

endmodule

FILE: rtl/dss_queue.sv
module dss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dss_pkg::event_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output dss_pkg::event_t head
);

	localparam int AW = $clog2(dss_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(dss_pkg::QUEUE_DEPTH + 1);

	dss_pkg::event_t entry_q [dss_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(dss_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Storage for queued events.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/dss_back.sv
module dss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ev_valid,
	input  dss_pkg::event_t            ev,
	output logic                       ev_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output dss_pkg::result_t           out_word
);

	logic             valid_q;
	dss_pkg::result_t word_q;
	logic             second_q;
	logic             load;
	dss_pkg::result_t next_word;

	assign load      = ev_valid && (!valid_q || out_ready);
	assign ev_pop    = load && (!ev.two || second_q);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// Pick the first result or the trailing empty final segment.
	always_comb begin
		if (second_q) begin
			next_word.start  = ev.second_start;
			next_word.length = '0;
			next_word.last   = 1'b1;
			next_word.status = dss_pkg::STATUS_OK;
		end else begin
			next_word = ev.first;
		end
	end

	// Output register and position within a two-word event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= ev.two && !second_q;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

endmodule

FILE: rtl/delimiter_split_stream.sv
// Splits a byte stream on a configured delimiter of up to MAX_DELIM_BYTES bytes
// and reports each segment as a start position and length. The block accepts
// one byte per clock; the delimiter is compared against a window of the most
// recent bytes in parallel, so acceptance is limited only by the event queue
// between the classifier and the output stage. A byte produces at most one
// queued event, and an event yields one output word per cycle while m_tready
// is high, two words when a delimiter completes on the final byte (the segment
// before it, then an empty final segment). Results are queued, then registered.
// Positions are counted in POS_WIDTH bits and reported in 16-bit fields; a
// string longer than 2^POS_WIDTH - 1 bytes gives a single overflow result on
// its final byte. Configuration must be written only while the block is idle;
// it is not enforced. A delimiter length above MAX_DELIM_BYTES saturates, and
// length zero splits on every byte. No clearing pass is needed after reset.
module delimiter_split_stream #(
	parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES_DEF,
	parameter int POS_WIDTH       = dss_pkg::POS_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dss_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tlast,   // last_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [15:0] seg_start, [31:16] seg_length
	output logic                           m_tlast,   // last_segment
	output logic [1:0]                     m_tuser    // [1:0] status
);

	logic             ev_push;
	dss_pkg::event_t  ev_in;
	logic             q_full;
	logic             q_not_empty;
	dss_pkg::event_t  q_head;
	logic             q_pop;
	dss_pkg::result_t out_word;

	// Classifier: window compare, position tracking and event building.
	dss_front #(
		.MAX_DELIM_BYTES(MAX_DELIM_BYTES),
		.POS_WIDTH      (POS_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.queue_full(q_full),
		.ev_push   (ev_push),
		.ev        (ev_in)
	);

	// Event queue decoupling the classifier from the output stage.
	dss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_push),
		.push_data(ev_in),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	// Output stage: expands events into result words.
	dss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (q_not_empty),
		.ev       (q_head),
		.ev_pop   (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_word (out_word)
	);

	assign m_tdata = {out_word.length, out_word.start};
	assign m_tlast = out_word.last;
	assign m_tuser = out_word.status;

endmodule
